>>> design/rft_pkg.sv
// shared types, codes and constants of the rds2 file transfer group sequencer
package rft_pkg;

    localparam int OPCODE_W    = 2;
    localparam int ADDR_W      = 18;
    localparam int VALUE_W     = 16;
    localparam int BLOCK_W     = 16;
    localparam int KIND_W      = 2;
    localparam int LEN_W       = 18;
    localparam int SEG_W       = 15;
    localparam int CHUNK_W     = 9;
    localparam int SEG_CNT_W   = 16;
    localparam int CHUNK_CNT_W = 10;
    localparam int PHASE_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    localparam int SEGMENT_BYTES = 5;
    localparam int QUEUE_DEPTH   = 4;

    localparam int DEFAULT_MAX_FILE_BYTES = 163840;
    localparam int DEFAULT_MAX_CHUNKS     = 512;

    localparam logic [OPCODE_W-1:0] OP_WRITE_BYTE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE_CRC  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EMIT       = 2'd2;

    localparam logic [KIND_W-1:0] KIND_META = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CRC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_PIPE_NUMBER  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILE_LENGTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_MODE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FILE_VERSION = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FILE_IDENT   = 3'd4;

    localparam logic [3:0] PIPE_RESET     = 4'd8;
    localparam logic [2:0] CRC_MODE_RESET = 3'd7;

    localparam logic [BLOCK_W-1:0] ODA_AID        = 16'hFF7F;
    localparam logic [BLOCK_W-1:0] DATA_HEADER    = 16'(2 << 12);
    localparam logic [BLOCK_W-1:0] VARIANT_HEADER = 16'((2 << 6) << 8);
    localparam logic [LEN_W-1:0]   CHUNK64_ABOVE  = 18'd81960;
    localparam logic [LEN_W-1:0]   CHUNK32_ABOVE  = 18'd40960;

    // ceil(len / 5) as ((len + 4) * 52429) >> 18, exact for len + 4 below 2**18
    localparam int              RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_5  = 16'd52429;
    localparam int              RECIP_SHIFT = 18;

    localparam logic [2:0] CHUNK_SHIFT_16 = 3'd4;
    localparam logic [2:0] CHUNK_SHIFT_32 = 3'd5;
    localparam logic [2:0] CHUNK_SHIFT_64 = 3'd6;

    typedef enum logic [1:0] {
        CMD_WRITE_BYTE,
        CMD_WRITE_CRC,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [ADDR_W-1:0]   address;
        logic [VALUE_W-1:0]  value;
    } entry_t;

    typedef struct packed {
        logic [3:0]             pipe;
        logic [LEN_W-1:0]       file_length;
        logic [2:0]             crc_mode;
        logic [2:0]             version;
        logic [5:0]             ident;
        logic [LEN_W-1:0]       eff_len;
        logic [SEG_CNT_W-1:0]   seg_count;
        logic [CHUNK_CNT_W-1:0] chunk_count;
        logic                   settling;
    } cfg_t;

endpackage

>>> design/rft_front.sv
// front end: accepts input transactions, decodes and filters them for the queue
module rft_front #(
    parameter int MAX_FILE_BYTES = rft_pkg::DEFAULT_MAX_FILE_BYTES,
    parameter int MAX_CHUNKS     = rft_pkg::DEFAULT_MAX_CHUNKS
) (
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [rft_pkg::OPCODE_W-1:0]  opcode,
    input  logic [rft_pkg::ADDR_W-1:0]    address,
    input  logic [rft_pkg::VALUE_W-1:0]   value,
    output logic                          push,
    output rft_pkg::entry_t               entry
);
    import rft_pkg::*;

    localparam logic [ADDR_W-1:0] BYTE_LIMIT  = ADDR_W'(MAX_FILE_BYTES);
    localparam logic [ADDR_W-1:0] CHUNK_LIMIT = ADDR_W'(MAX_CHUNKS);

    logic keep;

    always_comb
    begin
        keep          = 1'b0;
        entry.cmd     = CMD_EMIT;
        entry.address = address;
        entry.value   = value;
        unique case (opcode)
            OP_WRITE_BYTE:
            begin
                entry.cmd = CMD_WRITE_BYTE;
                keep      = address < BYTE_LIMIT;
            end
            OP_WRITE_CRC:
            begin
                entry.cmd = CMD_WRITE_CRC;
                keep      = address < CHUNK_LIMIT;
            end
            OP_EMIT:
            begin
                entry.cmd = CMD_EMIT;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = in_valid && !in_stall && keep;

endmodule

>>> design/rft_queue.sv
// short command queue between front and back end
module rft_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rft_pkg::entry_t push_entry,
    input  logic            pop,
    output rft_pkg::entry_t head,
    output logic            empty,
    output logic            full
);
    import rft_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    entry_t            slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = count_reg == '0;
    assign full    = count_reg == FULL_CNT;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> design/rft_back.sv
// back end: file and crc stores, group sequencing and output register
module rft_back #(
    parameter int MAX_FILE_BYTES = rft_pkg::DEFAULT_MAX_FILE_BYTES,
    parameter int MAX_CHUNKS     = rft_pkg::DEFAULT_MAX_CHUNKS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rft_pkg::cfg_t                cfg,
    input  logic                         empty,
    input  rft_pkg::entry_t              head,
    output logic                         pop,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [rft_pkg::BLOCK_W-1:0]  block_a,
    output logic [rft_pkg::BLOCK_W-1:0]  block_b,
    output logic [rft_pkg::BLOCK_W-1:0]  block_c,
    output logic [rft_pkg::BLOCK_W-1:0]  block_d,
    output logic [rft_pkg::KIND_W-1:0]   group_kind
);
    import rft_pkg::*;

    localparam int FA_W    = $clog2(MAX_FILE_BYTES);
    localparam int CA_W    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int BYTES_W = BYTE_W * SEGMENT_BYTES;

    localparam logic [CHUNK_CNT_W-1:0] CHUNK_LIMIT = CHUNK_CNT_W'(MAX_CHUNKS);
    localparam logic [2:0]             LAST_BYTE   = 3'(SEGMENT_BYTES - 1);
    localparam logic [PHASE_W-1:0]     PHASE_META  = 4'd0;
    localparam logic [PHASE_W-1:0]     PHASE_CRC   = 4'd1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [BYTE_W-1:0]      file_mem [MAX_FILE_BYTES];
    logic [VALUE_W-1:0]     crc_mem  [MAX_CHUNKS];

    logic [1:0]             state_reg;
    logic [PHASE_W-1:0]     phase_reg;
    logic [SEG_W-1:0]       seg_reg;
    logic [CHUNK_W-1:0]     chunk_reg;
    logic [KIND_W-1:0]      kind_reg;
    logic [2:0]             cnt_reg;
    logic                   fetch_reg;
    logic                   out_valid_reg;

    logic [LEN_W-1:0]       addr_reg;
    logic                   fetch_ok_reg;
    logic [BYTE_W-1:0]      file_data_reg;
    logic [VALUE_W-1:0]     crc_data_reg;
    logic                   crc_ok_reg;
    logic [BYTES_W-1:0]     bytes_reg;
    logic [BLOCK_W-1:0]     block_a_reg;
    logic [BLOCK_W-1:0]     block_b_reg;
    logic [BLOCK_W-1:0]     block_c_reg;
    logic [BLOCK_W-1:0]     block_d_reg;
    logic [KIND_W-1:0]      kind_out_reg;

    logic                   emit_pop;
    logic                   file_wr;
    logic                   crc_wr;
    logic [LEN_W-1:0]       seg_base;
    logic [LEN_W-1:0]       rd_addr;
    logic                   rd_issue;
    logic                   rd_ok;
    logic                   file_rd_en;
    logic                   crc_ok;
    logic                   crc_rd_en;
    logic                   slot_free;
    logic                   load;
    logic [SEG_W-1:0]       seg_inc;
    logic [SEG_W-1:0]       seg_next;
    logic [CHUNK_W-1:0]     chunk_inc;
    logic [CHUNK_W-1:0]     chunk_next;
    logic [BLOCK_W-1:0]     a_next;
    logic [BLOCK_W-1:0]     b_next;
    logic [BLOCK_W-1:0]     c_next;
    logic [BLOCK_W-1:0]     d_next;

    assign pop      = (state_reg == S_IDLE) && !empty;
    assign emit_pop = pop && (head.cmd == CMD_EMIT);
    assign file_wr  = pop && (head.cmd == CMD_WRITE_BYTE);
    assign crc_wr   = pop && (head.cmd == CMD_WRITE_CRC);

    // segment address times five
    assign seg_base   = LEN_W'({seg_reg, 2'b00}) + LEN_W'(seg_reg);
    assign rd_addr    = (state_reg == S_IDLE) ? seg_base : addr_reg;
    assign rd_issue   = (emit_pop && (phase_reg > PHASE_CRC)) || (state_reg == S_READ);
    assign rd_ok      = rd_addr < cfg.eff_len;
    assign file_rd_en = rd_issue && rd_ok;

    assign crc_ok    = CHUNK_CNT_W'(chunk_reg) < CHUNK_LIMIT;
    assign crc_rd_en = emit_pop && (phase_reg == PHASE_CRC) && crc_ok;

    assign slot_free = !out_valid_reg || !out_stall;
    assign load      = (state_reg == S_OUT) && !fetch_reg && !cfg.settling && slot_free;

    assign seg_inc    = seg_reg + 1'b1;
    assign seg_next   = (SEG_CNT_W'(seg_inc) >= cfg.seg_count) ? '0 : seg_inc;
    assign chunk_inc  = chunk_reg + 1'b1;
    assign chunk_next = (CHUNK_CNT_W'(chunk_inc) >= cfg.chunk_count) ? '0 : chunk_inc;

    always_comb
    begin
        a_next = '0;
        b_next = '0;
        c_next = '0;
        d_next = '0;
        unique case (kind_reg)
            KIND_META:
            begin
                a_next = VARIANT_HEADER | BLOCK_W'(cfg.pipe);
                b_next = ODA_AID;
                c_next = {4'b0000, cfg.crc_mode[0], cfg.version, cfg.ident,
                          cfg.file_length[17:16]};
                d_next = cfg.file_length[15:0];
            end
            KIND_CRC:
            begin
                a_next = VARIANT_HEADER | BLOCK_W'(cfg.pipe);
                b_next = ODA_AID;
                c_next = {3'b000, 1'b1, cfg.crc_mode, chunk_reg};
                d_next = crc_ok_reg ? crc_data_reg : '0;
            end
            KIND_DATA:
            begin
                a_next = DATA_HEADER | {4'b0000, cfg.pipe, 1'b0, seg_reg[14:8]};
                b_next = {seg_reg[7:0], bytes_reg[39:32]};
                c_next = bytes_reg[31:16];
                d_next = bytes_reg[15:0];
            end
            default:
            begin
                a_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            seg_reg       <= '0;
            chunk_reg     <= '0;
            kind_reg      <= KIND_META;
            cnt_reg       <= '0;
            fetch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fetch_reg <= rd_issue;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (emit_pop)
                    begin
                        if (phase_reg == PHASE_META)
                        begin
                            kind_reg  <= KIND_META;
                            state_reg <= S_OUT;
                        end
                        else if (phase_reg == PHASE_CRC)
                        begin
                            kind_reg  <= KIND_CRC;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            kind_reg  <= KIND_DATA;
                            cnt_reg   <= 3'd1;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_BYTE)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (load)
                    begin
                        state_reg <= S_IDLE;
                        phase_reg <= phase_reg + 1'b1;
                        if (kind_reg == KIND_CRC)
                        begin
                            chunk_reg <= chunk_next;
                        end
                        if (kind_reg == KIND_DATA)
                        begin
                            seg_reg <= seg_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            addr_reg     <= LEN_W'(rd_addr + 1'b1);
            fetch_ok_reg <= rd_ok;
        end
        if (fetch_reg)
        begin
            bytes_reg <= {bytes_reg[BYTES_W-BYTE_W-1:0],
                          fetch_ok_reg ? file_data_reg : {BYTE_W{1'b0}}};
        end
        if (emit_pop && (phase_reg == PHASE_CRC))
        begin
            crc_ok_reg <= crc_ok;
        end
        if (load)
        begin
            block_a_reg  <= a_next;
            block_b_reg  <= b_next;
            block_c_reg  <= c_next;
            block_d_reg  <= d_next;
            kind_out_reg <= kind_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (file_wr)
        begin
            file_mem[head.address[FA_W-1:0]] <= head.value[BYTE_W-1:0];
        end
        if (file_rd_en)
        begin
            file_data_reg <= file_mem[rd_addr[FA_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (crc_wr)
        begin
            crc_mem[head.address[CA_W-1:0]] <= head.value;
        end
        if (crc_rd_en)
        begin
            crc_data_reg <= crc_mem[chunk_reg[CA_W-1:0]];
        end
    end

    assign out_valid  = out_valid_reg;
    assign block_a    = block_a_reg;
    assign block_b    = block_b_reg;
    assign block_c    = block_c_reg;
    assign block_d    = block_d_reg;
    assign group_kind = kind_out_reg;

endmodule

>>> design/rds2_file_transfer_group_sequencer.sv
// top level: config registers, segment and chunk counts, front, queue and back end
//
//  channel   handshake             payload
//  -------   -------------------   -------------------------------------------
//  input     in_valid / in_stall   opcode, address, value
//  output    out_valid / out_stall block_a, block_b, block_c, block_d, group_kind
//  config    cfg_wr_en             cfg_index, cfg_wdata
//
// byte and crc writes complete on the pop from the queue; a metadata or crc group goes
// from idle straight to the output load, while a data group first takes five reads on the
// single read port of the file store plus the registered read; the queue registers each entry
// reset clears control state only; both stores hold garbage until written
// in_stall rises while the four-entry queue is full; the output register holds
// a group under out_stall while the front keeps filling the queue
module rds2_file_transfer_group_sequencer #(
    parameter int MAX_FILE_BYTES = rft_pkg::DEFAULT_MAX_FILE_BYTES,
    parameter int MAX_CHUNKS     = rft_pkg::DEFAULT_MAX_CHUNKS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rft_pkg::OPCODE_W-1:0]    opcode,
    input  logic [rft_pkg::ADDR_W-1:0]      address,
    input  logic [rft_pkg::VALUE_W-1:0]     value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rft_pkg::BLOCK_W-1:0]     block_a,
    output logic [rft_pkg::BLOCK_W-1:0]     block_b,
    output logic [rft_pkg::BLOCK_W-1:0]     block_c,
    output logic [rft_pkg::BLOCK_W-1:0]     block_d,
    output logic [rft_pkg::KIND_W-1:0]      group_kind,
    input  logic                            cfg_wr_en,
    input  logic [rft_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rft_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rft_pkg::*;

    localparam int PROD_W = LEN_W + 1 + RECIP_W;
    localparam int SUM_W  = SEG_CNT_W + 1;

    localparam logic [LEN_W-1:0] LEN_LIMIT   = LEN_W'(MAX_FILE_BYTES);
    localparam logic [SUM_W-1:0] CHUNK_LIMIT = SUM_W'(MAX_CHUNKS);

    logic [3:0]             pipe_reg;
    logic [LEN_W-1:0]       file_length_reg;
    logic [2:0]             crc_mode_reg;
    logic [2:0]             version_reg;
    logic [5:0]             ident_reg;
    logic [SEG_CNT_W-1:0]   seg_count_reg;
    logic [2:0]             shift_reg;
    logic [CHUNK_CNT_W-1:0] chunk_count_reg;
    logic [1:0]             settle_reg;

    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W:0]         round_up;
    logic [PROD_W-1:0]      product;
    logic [2:0]             shift_next;
    logic [SUM_W-1:0]       chunk_sum;
    logic [SUM_W-1:0]       chunk_wide;

    cfg_t                   cfg;
    entry_t                 entry;
    entry_t                 head;
    logic                   push;
    logic                   pop;
    logic                   q_empty;
    logic                   q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_reg        <= PIPE_RESET;
            file_length_reg <= '0;
            crc_mode_reg    <= CRC_MODE_RESET;
            version_reg     <= '0;
            ident_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PIPE_NUMBER:  pipe_reg        <= cfg_wdata[3:0];
                REG_FILE_LENGTH:  file_length_reg <= cfg_wdata[LEN_W-1:0];
                REG_CRC_MODE:     crc_mode_reg    <= cfg_wdata[2:0];
                REG_FILE_VERSION: version_reg     <= cfg_wdata[2:0];
                REG_FILE_IDENT:   ident_reg       <= cfg_wdata[5:0];
                default:
                begin
                end
            endcase
        end
    end

    assign eff_len  = (file_length_reg > LEN_LIMIT) ? LEN_LIMIT : file_length_reg;
    assign round_up = (LEN_W + 1)'(eff_len) + (LEN_W + 1)'(SEGMENT_BYTES - 1);
    assign product  = PROD_W'(round_up) * PROD_W'(RECIP_5);

    always_comb
    begin
        if (eff_len > CHUNK64_ABOVE)
        begin
            shift_next = CHUNK_SHIFT_64;
        end
        else if (eff_len > CHUNK32_ABOVE)
        begin
            shift_next = CHUNK_SHIFT_32;
        end
        else
        begin
            shift_next = CHUNK_SHIFT_16;
        end
    end

    // ceil(segments / chunk segments)
    assign chunk_sum  = SUM_W'(seg_count_reg) + ((SUM_W'(1) << shift_reg) - SUM_W'(1));
    assign chunk_wide = chunk_sum >> shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg   <= '0;
            shift_reg       <= CHUNK_SHIFT_16;
            chunk_count_reg <= '0;
            settle_reg      <= '0;
        end
        else
        begin
            seg_count_reg   <= product[RECIP_SHIFT +: SEG_CNT_W];
            shift_reg       <= shift_next;
            chunk_count_reg <= (chunk_wide > CHUNK_LIMIT) ? CHUNK_LIMIT[CHUNK_CNT_W-1:0]
                                                          : chunk_wide[CHUNK_CNT_W-1:0];
            settle_reg      <= {settle_reg[0], cfg_wr_en};
        end
    end

    always_comb
    begin
        cfg.pipe        = pipe_reg;
        cfg.file_length = file_length_reg;
        cfg.crc_mode    = crc_mode_reg;
        cfg.version     = version_reg;
        cfg.ident       = ident_reg;
        cfg.eff_len     = eff_len;
        cfg.seg_count   = seg_count_reg;
        cfg.chunk_count = chunk_count_reg;
        cfg.settling    = |settle_reg;
    end

    assign in_stall = q_full;

    rft_front #(
        .MAX_FILE_BYTES (MAX_FILE_BYTES),
        .MAX_CHUNKS     (MAX_CHUNKS)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (q_full),
        .opcode   (opcode),
        .address  (address),
        .value    (value),
        .push     (push),
        .entry    (entry)
    );

    rft_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    rft_back #(
        .MAX_FILE_BYTES (MAX_FILE_BYTES),
        .MAX_CHUNKS     (MAX_CHUNKS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .empty      (q_empty),
        .head       (head),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .block_a    (block_a),
        .block_b    (block_b),
        .block_c    (block_c),
        .block_d    (block_d),
        .group_kind (group_kind)
    );

    a_data_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((group_kind == KIND_DATA) == (block_a[15:12] == DATA_HEADER[15:12])))
        else $error("group kind does not match block a header");

    a_variant_aid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (group_kind != KIND_DATA)
        |-> (block_b == ODA_AID) && (block_a[15:8] == VARIANT_HEADER[15:8]))
        else $error("variant group without application id");

    a_meta_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (group_kind == KIND_META)
        |-> (block_d == file_length_reg[15:0]) && (block_c[1:0] == file_length_reg[17:16]))
        else $error("metadata group length differs from register");

endmodule
